>>> hw/rtl/afn_pkg.sv
// ----------------------------------------------------------------------------
// afn_pkg
// Shared types, constants and byte-folding functions for the accent folding
// normalizer.
// ----------------------------------------------------------------------------
package afn_pkg;

   localparam int ByteWidth     = 8;
   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam logic [ByteWidth-1:0] LeadByte  = 8'hC3;
   localparam logic [ByteWidth-1:0] NulByte   = 8'h00;
   localparam logic [ByteWidth-1:0] StarByte  = 8'h2A;
   localparam logic [ByteWidth-1:0] SpaceByte = 8'h20;
   localparam logic [ByteWidth-1:0] QuestByte = 8'h3F;
   localparam logic [ByteWidth-1:0] UpperA    = 8'h41;
   localparam logic [ByteWidth-1:0] UpperZ    = 8'h5A;
   localparam logic [ByteWidth-1:0] CaseDelta = 8'h20;

   localparam logic [ByteWidth-1:0] FoldALo = 8'hA0;
   localparam logic [ByteWidth-1:0] FoldAHi = 8'hA5;
   localparam logic [ByteWidth-1:0] FoldELo = 8'hA8;
   localparam logic [ByteWidth-1:0] FoldEHi = 8'hAB;
   localparam logic [ByteWidth-1:0] FoldILo = 8'hAC;
   localparam logic [ByteWidth-1:0] FoldIHi = 8'hAF;
   localparam logic [ByteWidth-1:0] FoldOLo = 8'hB2;
   localparam logic [ByteWidth-1:0] FoldOHi = 8'hB7;
   localparam logic [ByteWidth-1:0] FoldULo = 8'hB9;
   localparam logic [ByteWidth-1:0] FoldUHi = 8'hBE;
   localparam logic [ByteWidth-1:0] FoldC   = 8'hA7;
   localparam logic [ByteWidth-1:0] FoldN   = 8'hB1;

   localparam logic [ByteWidth-1:0] CharA = 8'h61;
   localparam logic [ByteWidth-1:0] CharE = 8'h65;
   localparam logic [ByteWidth-1:0] CharI = 8'h69;
   localparam logic [ByteWidth-1:0] CharO = 8'h6F;
   localparam logic [ByteWidth-1:0] CharU = 8'h75;
   localparam logic [ByteWidth-1:0] CharC = 8'h63;
   localparam logic [ByteWidth-1:0] CharN = 8'h6E;

   // One classified input byte: one or two output bytes.
   typedef struct packed {
      logic                 pair;
      logic [ByteWidth-1:0] first;
      logic [ByteWidth-1:0] second;
   } fold_entry_type;

   // Base letter for a follower of the lead byte, zero when unmatched.
   function automatic logic [ByteWidth-1:0] fold_follower(input logic [ByteWidth-1:0] f);
      logic [ByteWidth-1:0] res;
      res = NulByte;
      if (f >= FoldALo && f <= FoldAHi) res = CharA;
      else if (f >= FoldELo && f <= FoldEHi) res = CharE;
      else if (f >= FoldILo && f <= FoldIHi) res = CharI;
      else if (f >= FoldOLo && f <= FoldOHi) res = CharO;
      else if (f >= FoldULo && f <= FoldUHi) res = CharU;
      else if (f == FoldC) res = CharC;
      else if (f == FoldN) res = CharN;
      return res;
   endfunction

   function automatic logic [ByteWidth-1:0] lower_ascii(input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] res;
      res = b;
      if (b >= UpperA && b <= UpperZ) res = b + CaseDelta;
      return res;
   endfunction

endpackage

>>> hw/rtl/afn_front.sv
// ----------------------------------------------------------------------------
// afn_front
// Accepts input bytes, tracks leading-skip and pending-lead state, and turns
// each byte into zero, one or two output bytes for the queue.
// ----------------------------------------------------------------------------
module afn_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [afn_pkg::ByteWidth-1:0] req_tdata,
   input  logic                          queue_full,
   output logic                          push_valid,
   output afn_pkg::fold_entry_type       push_entry
);
   import afn_pkg::*;

   logic skip_ff, skip_in;
   logic lead_ff, lead_in;
   logic accept;
   logic emit;
   logic [ByteWidth-1:0] folded;
   fold_entry_type entry;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      folded       = fold_follower(req_tdata);
      skip_in      = skip_ff;
      lead_in      = lead_ff;
      emit         = 1'b0;
      entry.pair   = 1'b0;
      entry.first  = lower_ascii(req_tdata);
      entry.second = lower_ascii(req_tdata);
      if (lead_ff) begin
         lead_in = 1'b0;
         emit    = 1'b1;
         if (folded != NulByte) begin
            entry.first = folded;
         end else begin
            // unmatched follower: lead goes out as is, follower handled plainly
            entry.first = LeadByte;
            skip_in     = (req_tdata == NulByte);
            if (req_tdata == LeadByte) begin
               lead_in = 1'b1;
            end else begin
               entry.pair = 1'b1;
            end
         end
      end else if (skip_ff && (req_tdata == StarByte || req_tdata == SpaceByte ||
                               req_tdata == QuestByte)) begin
         emit = 1'b0;
      end else begin
         skip_in = (req_tdata == NulByte);
         if (req_tdata == LeadByte) begin
            lead_in = 1'b1;
         end else begin
            emit = 1'b1;
         end
      end
   end

   assign push_valid = accept && emit;
   assign push_entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b1;
         lead_ff <= 1'b0;
      end else if (accept) begin
         skip_ff <= skip_in;
         lead_ff <= lead_in;
      end
   end

endmodule

>>> hw/rtl/afn_queue.sv
// ----------------------------------------------------------------------------
// afn_queue
// Short FIFO of classified entries between the front and the back end.
// ----------------------------------------------------------------------------
module afn_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  afn_pkg::fold_entry_type push_entry,
   output logic                    full,
   input  logic                    pop,
   output logic                    empty,
   output afn_pkg::fold_entry_type pop_entry
);
   import afn_pkg::*;

   fold_entry_type slot_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full      = (count_ff == QueueCntWidth'(QueueDepth));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

>>> hw/rtl/afn_back.sv
// ----------------------------------------------------------------------------
// afn_back
// Pops queue entries and sends their one or two bytes out through the
// output register, one byte per transfer.
// ----------------------------------------------------------------------------
module afn_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          empty,
   input  afn_pkg::fold_entry_type       pop_entry,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [afn_pkg::ByteWidth-1:0] rsp_tdata,
   output logic                          rsp_tlast
);
   import afn_pkg::*;

   logic                 valid_ff, valid_in;
   logic [ByteWidth-1:0] data_ff, data_in;
   logic                 last_ff, last_in;
   logic                 second_ff, second_in;
   logic [ByteWidth-1:0] hold_ff, hold_in;
   logic                 out_free;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in  = valid_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      second_in = second_ff;
      hold_in   = hold_ff;
      pop       = 1'b0;
      if (out_free) begin
         if (second_ff) begin
            valid_in  = 1'b1;
            data_in   = hold_ff;
            last_in   = 1'b1;
            second_in = 1'b0;
         end else if (!empty) begin
            pop       = 1'b1;
            valid_in  = 1'b1;
            data_in   = pop_entry.first;
            last_in   = !pop_entry.pair;
            second_in = pop_entry.pair;
            hold_in   = pop_entry.second;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
      hold_ff <= hold_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> hw/rtl/accent_folding_normalizer_top.sv
// ----------------------------------------------------------------------------
// accent_folding_normalizer_top
// Byte stream normalizer: leading-skip, Latin-1 accent folding, ASCII
// lowercasing of NUL-terminated strings.
//
//   channel | direction | tdata                | tlast
//   req_    | in        | [7:0] byte_in        | -
//   rsp_    | out       | [7:0] byte_out       | last_of_run
//
// One input byte is taken per cycle while the queue has room. Each byte gives
// zero, one or two output bytes; the output register sends one per cycle while
// rsp_tready is high. An input byte passes through a queue slot and then the
// output register. A stalled output fills the four-entry queue before
// req_tready drops. Reset is synchronous and clears the string state and queue.
// ----------------------------------------------------------------------------
module accent_folding_normalizer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [afn_pkg::ByteWidth-1:0] req_tdata,   // [7:0] byte_in
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [afn_pkg::ByteWidth-1:0] rsp_tdata,   // [7:0] byte_out
   output logic                          rsp_tlast
);
   import afn_pkg::*;

   logic           push_valid;
   fold_entry_type push_entry;
   logic           queue_full;
   logic           queue_empty;
   logic           pop;
   fold_entry_type pop_entry;

   afn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   afn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .empty      (queue_empty),
      .pop_entry  (pop_entry)
   );

   afn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (queue_empty),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> hw/rtl/afn_checker.sv
// ----------------------------------------------------------------------------
// afn_checker
// Port-level checks for the accent folding normalizer, bound to the top.
// ----------------------------------------------------------------------------
module afn_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [afn_pkg::ByteWidth-1:0] req_tdata,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [afn_pkg::ByteWidth-1:0] rsp_tdata,
   input logic                          rsp_tlast
);
   import afn_pkg::*;

   // stalled output transfer holds its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // only an unmatched lead opens a two-byte result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata == LeadByte)
      else $error("non-last byte is not the lead byte");

   // second byte of a pair follows right away
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("second byte of pair missing");

   // an accepted input transfer carries a known byte
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !$isunknown(req_tdata))
      else $error("unknown byte accepted on req");

endmodule

bind accent_folding_normalizer_top afn_checker u_afn_checker (.*);
